[hdl/tsms_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsms_pkg: shared constants for the time-slot message scheduler
// Field widths, slot windows, message identifiers and register reset values.
// ---------------------------------------------------------------------------
package tsms_pkg;

  localparam int unsigned TickW   = 9;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned IdW     = 3;
  localparam int unsigned SlotCnt = 5;
  localparam int unsigned M50W    = 6;
  localparam int unsigned M100W   = 7;

  // Input item function codes
  localparam logic FuncTick = 1'b0;
  localparam logic FuncPoll = 1'b1;

  // Slot positions in priority order
  localparam int unsigned SlotBatt  = 0;
  localparam int unsigned SlotUltra = 1;
  localparam int unsigned SlotRight = 2;
  localparam int unsigned SlotLeft  = 3;
  localparam int unsigned SlotSteer = 4;

  // Message identifiers
  localparam logic [IdW-1:0] IdBatt  = 3'd7;
  localparam logic [IdW-1:0] IdUltra = 3'd6;
  localparam logic [IdW-1:0] IdRight = 3'd0;
  localparam logic [IdW-1:0] IdLeft  = 3'd1;
  localparam logic [IdW-1:0] IdSteer = 3'd2;

  localparam logic [TickW-1:0] WrapReset = 9'd500;

  // Modulo counter tops
  localparam logic [M50W-1:0]  M50Top  = 6'd49;
  localparam logic [M100W-1:0] M100Top = 7'd99;

  // Window bounds
  localparam logic [TickW-1:0] BattLo  = 9'd5;
  localparam logic [TickW-1:0] BattHi  = 9'd7;
  localparam logic [M50W-1:0]  UltraHi = 6'd2;
  localparam logic [M50W-1:0]  RightLo = 6'd10;
  localparam logic [M50W-1:0]  RightHi = 6'd12;
  localparam logic [M50W-1:0]  LeftLo  = 6'd20;
  localparam logic [M50W-1:0]  LeftHi  = 6'd22;
  localparam logic [M100W-1:0] SteerLo = 7'd15;
  localparam logic [M100W-1:0] SteerHi = 7'd17;

  typedef logic [SlotCnt-1:0] slot_vec_t;
  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [IdW-1:0]     msg_id_t;
  typedef logic [TickW-1:0]   tick_t;

endpackage

[hdl/tsms_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsms_if: channel interfaces of the scheduler
// Input item channel, result channel and configuration write channel.
// ---------------------------------------------------------------------------
interface tsms_in_if;
  logic                 valid;
  logic                 ready;
  logic                 func;
  tsms_pkg::byte_t      battery_level;
  tsms_pkg::byte_t      steering_angle;
  tsms_pkg::byte_t      speed_left;
  tsms_pkg::byte_t      speed_right;
  tsms_pkg::byte_t      ultrasonic_range;
  logic                 tx_ready;

  modport source (output valid, func, battery_level, steering_angle, speed_left,
                  speed_right, ultrasonic_range, tx_ready, input ready);
  modport sink   (input valid, func, battery_level, steering_angle, speed_left,
                  speed_right, ultrasonic_range, tx_ready, output ready);
endinterface

interface tsms_out_if;
  logic              valid;
  logic              ready;
  logic              send_valid;
  tsms_pkg::msg_id_t msg_id;
  tsms_pkg::byte_t   msg_byte;
  tsms_pkg::tick_t   tick_now;

  modport source (output valid, send_valid, msg_id, msg_byte, tick_now, input ready);
  modport sink   (input valid, send_valid, msg_id, msg_byte, tick_now, output ready);
endinterface

interface tsms_cfg_if;
  logic            valid;
  logic            ready;
  tsms_pkg::tick_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[hdl/time_slot_message_scheduler_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// time_slot_message_scheduler_top: tick counter and slot-based send arbiter
//
// in_ch carries one transaction per item: func 0 advances the tick counter,
// func 1 polls the five send slots with the current measurement bytes and
// the transmitter ready flag. Every item yields exactly one transaction on
// out_ch with send_valid, msg_id, msg_byte and the tick value after the item.
// cfg_ch writes the tick wrap limit; it is always ready. The user must write it
// only while the block is idle; the block itself does not enforce this.
// The result of an accepted item is registered and shown in the cycle after
// its acceptance. Throughput is one item per cycle while out_ch is not
// stalled, set by the single output register. While out_ch is stalled the
// result holds and in_ch.ready drops, so no item is lost. The tick counter
// keeps running mod-50 and mod-100 companions so the periodic window checks
// are short compares. Reset clears the tick counter, the sent flags and the
// output valid, and loads the wrap limit with 500.
// ---------------------------------------------------------------------------
module time_slot_message_scheduler_top (
  input  logic        clk,
  input  logic        rst_n,
  tsms_in_if.sink     in_ch,
  tsms_out_if.source  out_ch,
  tsms_cfg_if.sink    cfg_ch
);

  // State
  tsms_pkg::tick_t                  wrap_r;
  tsms_pkg::tick_t                  tick_r, tick_nxt;
  logic [tsms_pkg::M50W-1:0]        m50_r, m50_nxt;
  logic [tsms_pkg::M100W-1:0]       m100_r, m100_nxt;
  tsms_pkg::slot_vec_t              sent_r, sent_nxt;

  // Result register
  logic              out_valid_r;
  logic              send_r, send_nxt;
  tsms_pkg::msg_id_t id_r, id_nxt;
  tsms_pkg::byte_t   byte_r, byte_nxt;

  logic                in_acc;
  tsms_pkg::slot_vec_t win;
  tsms_pkg::byte_t     slot_byte [tsms_pkg::SlotCnt];
  tsms_pkg::msg_id_t   slot_id   [tsms_pkg::SlotCnt];
  logic                rdy;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.send_valid = send_r;
  assign out_ch.msg_id     = id_r;
  assign out_ch.msg_byte   = byte_r;
  assign out_ch.tick_now   = tick_r;

  // Decode send windows from the tick and its modulo companions
  always_comb begin
    win[tsms_pkg::SlotBatt]  = (tick_r >= tsms_pkg::BattLo) && (tick_r <= tsms_pkg::BattHi);
    win[tsms_pkg::SlotUltra] = (m50_r <= tsms_pkg::UltraHi);
    win[tsms_pkg::SlotRight] = (m50_r >= tsms_pkg::RightLo) && (m50_r <= tsms_pkg::RightHi);
    win[tsms_pkg::SlotLeft]  = (m50_r >= tsms_pkg::LeftLo) && (m50_r <= tsms_pkg::LeftHi);
    win[tsms_pkg::SlotSteer] = (m100_r >= tsms_pkg::SteerLo) && (m100_r <= tsms_pkg::SteerHi);
  end

  // Map slots to their bytes and identifiers
  always_comb begin
    slot_byte[tsms_pkg::SlotBatt]  = in_ch.battery_level;
    slot_byte[tsms_pkg::SlotUltra] = in_ch.ultrasonic_range;
    slot_byte[tsms_pkg::SlotRight] = in_ch.speed_right;
    slot_byte[tsms_pkg::SlotLeft]  = in_ch.speed_left;
    slot_byte[tsms_pkg::SlotSteer] = in_ch.steering_angle;
    slot_id[tsms_pkg::SlotBatt]    = tsms_pkg::IdBatt;
    slot_id[tsms_pkg::SlotUltra]   = tsms_pkg::IdUltra;
    slot_id[tsms_pkg::SlotRight]   = tsms_pkg::IdRight;
    slot_id[tsms_pkg::SlotLeft]    = tsms_pkg::IdLeft;
    slot_id[tsms_pkg::SlotSteer]   = tsms_pkg::IdSteer;
  end

  // Advance the tick or arbitrate the slots for the accepted item
  always_comb begin
    tick_nxt = tick_r;
    m50_nxt  = m50_r;
    m100_nxt = m100_r;
    sent_nxt = sent_r;
    send_nxt = 1'b0;
    id_nxt   = '0;
    byte_nxt = '0;
    rdy      = in_ch.tx_ready;
    if (in_ch.func == tsms_pkg::FuncTick) begin
      if (tick_r >= wrap_r) begin
        tick_nxt = '0;
        m50_nxt  = '0;
        m100_nxt = '0;
      end else begin
        tick_nxt = tick_r + tsms_pkg::TickW'(1);
        m50_nxt  = (m50_r == tsms_pkg::M50Top) ? '0 : m50_r + tsms_pkg::M50W'(1);
        m100_nxt = (m100_r == tsms_pkg::M100Top) ? '0 : m100_r + tsms_pkg::M100W'(1);
      end
    end else begin
      // first open, unsent slot in priority order takes the ready line
      for (int s = 0; s < tsms_pkg::SlotCnt; s++) begin
        if (win[s]) begin
          if (!sent_r[s] && rdy) begin
            rdy         = 1'b0;
            send_nxt    = 1'b1;
            id_nxt      = slot_id[s];
            byte_nxt    = slot_byte[s];
            sent_nxt[s] = 1'b1;
          end
        end else begin
          sent_nxt[s] = 1'b0;
        end
      end
    end
  end

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r <= tsms_pkg::WrapReset;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      wrap_r <= cfg_ch.data;
    end
  end

  // Update state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      m50_r       <= '0;
      m100_r      <= '0;
      sent_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        tick_r      <= tick_nxt;
        m50_r       <= m50_nxt;
        m100_r      <= m100_nxt;
        sent_r      <= sent_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      send_r <= send_nxt;
      id_r   <= id_nxt;
      byte_r <= byte_nxt;
    end
  end

endmodule

[hdl/tsms_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsms_checker: port-level checks for the scheduler
// Watches the result channel and its relation to the input handshake.
// ---------------------------------------------------------------------------
module tsms_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              send_valid,
  input tsms_pkg::msg_id_t msg_id,
  input tsms_pkg::byte_t   msg_byte,
  input tsms_pkg::tick_t   tick_now
);

  // Hold a stalled result valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Hold a stalled result payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(send_valid) && $stable(msg_id)
                                && $stable(msg_byte) && $stable(tick_now))
    else $error("result payload changed while stalled");

  // Drop the result after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Zero message fields when nothing is sent
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !send_valid |-> msg_id == '0 && msg_byte == '0)
    else $error("message fields set without a send");

  // Accept input whenever the result register is free
  a_free_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind time_slot_message_scheduler_top tsms_checker u_tsms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .send_valid (out_ch.send_valid),
  .msg_id     (out_ch.msg_id),
  .msg_byte   (out_ch.msg_byte),
  .tick_now   (out_ch.tick_now)
);
